// ----- src/phtu_pkg.sv -----
package phtu_pkg;

  localparam int unsigned MaxLenDefault = 1024;
  localparam logic [63:0] BaseReset     = 64'd100000000003;

  // register map: 64-bit registers on 8-byte boundaries
  localparam int unsigned AddrW     = 4;
  localparam int unsigned RegIdxLsb = 3;
  localparam logic        RegBase   = 1'b0;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_ACC,
    S_FIN
  } state_e;

  typedef struct packed {
    logic       load;
    logic       read;
    logic       mul;
    logic [1:0] step;
    logic       acc;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic need_mul;
  } status_t;

  // addition modulo 2^64-1, end-around carry
  function automatic logic [63:0] mod_add(input logic [63:0] x, input logic [63:0] y);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[63:0] + {63'd0, s[64]};
  endfunction

  // times 2^32 modulo 2^64-1
  function automatic logic [63:0] rotl32(input logic [63:0] x);
    return {x[31:0], x[63:32]};
  endfunction

  function automatic logic [63:0] norm(input logic [63:0] x);
    return (x == '1) ? '0 : x;
  endfunction

endpackage

// ----- src/phtu_regs.sv -----
module phtu_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [phtu_pkg::AddrW-1:0]  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output logic [63:0]                 base_o
);
  import phtu_pkg::*;

  logic [63:0] base_q, base_d;
  logic        sel_base;

  assign sel_base = (paddr[AddrW-1:RegIdxLsb] == RegBase);
  assign pready   = 1'b1;
  assign prdata   = sel_base ? base_q : '0;
  assign base_o   = base_q;

  always_comb begin
    base_d = base_q;
    if (psel && penable && pwrite && sel_base) begin
      base_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else begin
      base_q <= base_d;
    end
  end

endmodule

// ----- src/phtu_ctrl.sv -----
module phtu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output phtu_pkg::cmd_t    cmd_o,
  input  phtu_pkg::status_t status_i
);
  import phtu_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        step_d     = '0;
        state_d    = status_i.need_mul ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd_o.mul  = 1'b1;
        cmd_o.step = step_q;
        cmd_o.acc  = (step_q != 2'd0);
        step_d     = step_q + 2'd1;
        if (step_q == 2'd3) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/phtu_dp.sv -----
module phtu_dp #(
  parameter  int unsigned MaxLen = phtu_pkg::MaxLenDefault,
  localparam int unsigned LenW   = $clog2(MaxLen + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  phtu_pkg::cmd_t    cmd_i,
  output phtu_pkg::status_t status_o,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        symbol_i,
  input  logic [LenW-1:0]   start_req_i,
  input  logic [LenW-1:0]   stop_i,
  input  logic [63:0]       base_i,
  output logic [63:0]       hash_o,
  output logic              error_o,
  output logic [LenW-1:0]   length_o
);
  import phtu_pkg::*;

  mode_e           mode_q;
  logic [7:0]      sym_q;
  logic [LenW-1:0] a_q, b_q;
  logic [LenW-1:0] len_q, len_d;

  logic [63:0] prefix_mem [MaxLen + 1];
  logic [63:0] power_mem  [MaxLen + 1];

  logic [63:0] pa_q, pb_q, pw_q;
  logic        za_q, zb_q, zw_q;
  logic [63:0] prod_a_q, prod_b_q;
  logic        rot_q;
  logic [63:0] acc_a_q, acc_b_q;
  logic [63:0] hash_q, hash_d;
  logic        err_q, err_d;

  logic            full, bad, is_query, is_append, wr_en;
  logic [LenW-1:0] addr_a, addr_b, addr_w, wr_addr;
  logic [63:0]     pa, pb, pw, xa, ya, xb, yb;
  logic [31:0]     xa_h, ya_h, xb_h, yb_h;
  logic [63:0]     prod_a, prod_b, term_a, term_b, new_prefix;

  assign is_query  = (mode_q == MODE_QUERY);
  assign is_append = (mode_q == MODE_APPEND);
  assign full      = (len_q == LenW'(MaxLen));
  assign bad       = (a_q > b_q) || (b_q > len_q);

  assign status_o.need_mul = (is_append && !full) || (is_query && !bad);

  assign addr_a  = is_query ? a_q : len_q;
  assign addr_b  = is_query ? b_q : len_q;
  assign addr_w  = is_query ? (b_q - a_q) : len_q;
  assign wr_addr = len_q + LenW'(1);
  assign wr_en   = cmd_i.commit && is_append && !full;

  // entry 0 of each table is fixed and never written
  assign pa = za_q ? 64'd0 : pa_q;
  assign pb = zb_q ? 64'd0 : pb_q;
  assign pw = zw_q ? 64'd1 : pw_q;

  assign xa = pa;
  assign ya = is_query ? pw : base_i;
  assign xb = pw;
  assign yb = base_i;

  // step bit 1 picks the high half of x, bit 0 that of y
  assign xa_h = cmd_i.step[1] ? xa[63:32] : xa[31:0];
  assign ya_h = cmd_i.step[0] ? ya[63:32] : ya[31:0];
  assign xb_h = cmd_i.step[1] ? xb[63:32] : xb[31:0];
  assign yb_h = cmd_i.step[0] ? yb[63:32] : yb[31:0];

  assign prod_a = {32'd0, xa_h} * {32'd0, ya_h};
  assign prod_b = {32'd0, xb_h} * {32'd0, yb_h};

  // cross terms carry weight 2^32; the high term's 2^64 folds to 1
  assign term_a = rot_q ? rotl32(prod_a_q) : prod_a_q;
  assign term_b = rot_q ? rotl32(prod_b_q) : prod_b_q;

  assign new_prefix = mod_add({56'd0, sym_q}, acc_a_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      pa_q <= prefix_mem[addr_a];
      pb_q <= prefix_mem[addr_b];
      pw_q <= power_mem[addr_w];
    end
    if (wr_en) begin
      prefix_mem[wr_addr] <= new_prefix;
      power_mem[wr_addr]  <= acc_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(mode_i);
      sym_q  <= symbol_i;
      a_q    <= start_req_i;
      b_q    <= stop_i;
    end
    if (cmd_i.read) begin
      za_q <= (addr_a == '0);
      zb_q <= (addr_b == '0);
      zw_q <= (addr_w == '0);
    end
    if (cmd_i.mul) begin
      prod_a_q <= prod_a;
      prod_b_q <= prod_b;
      rot_q    <= cmd_i.step[1] ^ cmd_i.step[0];
    end
    if (cmd_i.read) begin
      acc_a_q <= '0;
      acc_b_q <= '0;
    end else if (cmd_i.acc) begin
      acc_a_q <= mod_add(acc_a_q, term_a);
      acc_b_q <= mod_add(acc_b_q, term_b);
    end
    if (cmd_i.commit) begin
      hash_q <= hash_d;
      err_q  <= err_d;
    end
  end

  always_comb begin
    hash_d = '0;
    err_d  = 1'b0;
    len_d  = len_q;
    unique case (mode_q)
      MODE_CLEAR: begin
        len_d = '0;
      end
      MODE_APPEND: begin
        if (full) begin
          hash_d = norm(pb);
          err_d  = 1'b1;
        end else begin
          hash_d = norm(new_prefix);
          len_d  = wr_addr;
        end
      end
      MODE_QUERY: begin
        if (bad) begin
          err_d = 1'b1;
        end else begin
          hash_d = norm(mod_add(pb, ~acc_a_q));
        end
      end
      MODE_RSVD: begin
        hash_d = norm(pb);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cmd_i.commit) begin
      len_q <= len_d;
    end
  end

  assign hash_o   = hash_q;
  assign error_o  = err_q;
  assign length_o = len_q;

endmodule

// ----- src/prefix_polynomial_hash_table_unit.sv -----
// Prefix polynomial hash engine modulo 2^64-1. Each input transfer is a clear, an append
// of one byte, or a query of the hash of positions [start_req, stop); exactly one result
// transfer follows it. Clear, and any item that needs no product (full table, bad interval,
// unused mode), passes from its transfer through a table read to the finish step; an append
// or valid query adds the multiply steps and an accumulate step in between. The finish step
// commits the result once the previous result has been taken, and only then is the next input
// transfer accepted. The longer path is set by the 64x64 modular products:
// each lane has one 32x32 multiplier that steps through the four partial products, with
// a registered product and a fold into the end-around-carry accumulator behind it; an
// append runs its two products on two lanes at once. The prefix and power tables sit in
// memory with a registered read; their entry 0 is fixed, so no clearing pass follows
// reset. The base register sits at byte address 0 of the APB port and may be written only
// while the block is idle.
module prefix_polynomial_hash_table_unit #(
  parameter  int unsigned MaxLen = phtu_pkg::MaxLenDefault,
  localparam int unsigned LenW   = $clog2(MaxLen + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 mode_i,
  input  logic [7:0]                 symbol_i,
  input  logic [LenW-1:0]            start_req_i,
  input  logic [LenW-1:0]            stop_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [63:0]                hash_o,
  output logic                       error_o,
  output logic [LenW-1:0]            length_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [phtu_pkg::AddrW-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import phtu_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [63:0] base;

  phtu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .base_o  (base)
  );

  phtu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  phtu_dp #(
    .MaxLen (MaxLen)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .mode_i      (mode_i),
    .symbol_i    (symbol_i),
    .start_req_i (start_req_i),
    .stop_i      (stop_i),
    .base_i      (base),
    .hash_o      (hash_o),
    .error_o     (error_o),
    .length_o    (length_o)
  );

endmodule

// ----- src/phtu_chk.sv -----
module phtu_chk #(
  parameter  int unsigned MaxLen = phtu_pkg::MaxLenDefault,
  localparam int unsigned LenW   = $clog2(MaxLen + 1)
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [63:0]     hash_o,
  input logic            error_o,
  input logic [LenW-1:0] length_o
);
  import phtu_pkg::*;

  localparam logic [LenW-1:0] MaxLenW = LenW'(MaxLen);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hash_o) && $stable(error_o)
      && $stable(length_o))
    else $error("result changed while stalled");

  a_hash_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hash_o != 64'hFFFF_FFFF_FFFF_FFFF)
    else $error("hash not normalised");

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_o <= MaxLenW)
    else $error("length beyond capacity");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer taken while busy");

endmodule

bind prefix_polynomial_hash_table_unit phtu_chk #(
  .MaxLen (MaxLen)
) u_phtu_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .hash_o      (hash_o),
  .error_o     (error_o),
  .length_o    (length_o)
);
